// ===== rtl/hpt_pkg.sv =====
// Shared types, constants and codes of the homogeneous point transform.
package hpt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int ACC_W         = 66;
    localparam int QUO_W         = 33;
    localparam int MAT_ENTRIES   = 16;
    localparam int MAT_DEPTH     = 48;
    localparam int ADDR_W        = 6;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_IDENT = 2'd1;
    localparam logic [1:0] OP_XFORM = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] SEL_FWD  = 2'd0;
    localparam logic [1:0] SEL_INV  = 2'd1;
    localparam logic [1:0] SEL_INVT = 2'd2;
    localparam logic [1:0] SEL_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]                opcode;
        logic [1:0]                matrix_sel;
        logic [3:0]                entry_index;
        logic signed [COORD_W-1:0] entry_value;
        logic signed [COORD_W-1:0] x_in;
        logic signed [COORD_W-1:0] y_in;
        logic signed [COORD_W-1:0] z_in;
        logic signed [COORD_W-1:0] w_in;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
        logic signed [COORD_W-1:0] z_out;
        logic                      saturated;
    } result_t;

    typedef logic [3:0][COORD_W-1:0] vec4_t;
    typedef logic [3:0][ACC_W-1:0]   acc4_t;

    typedef struct packed {
        logic               wr_en;
        logic               ident_load;
        logic               rd_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ADDR_W-1:0]  rd_addr;
        logic [COORD_W-1:0] wr_data;
    } store_cmd_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] idx;
    } mac_tag_t;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic [COORD_W-1:0] value;
    } lane_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } hpt_state_t;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_CHK,
        DV_RUN,
        DV_RND,
        DV_FIN
    } dv_state_t;

endpackage

// ===== rtl/hpt_mat_store.sv =====
// Matrix store: 48-word synchronous memory with per-entry valid bits.
module hpt_mat_store #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hpt_pkg::store_cmd_t         cmd,
    output logic [hpt_pkg::COORD_W-1:0] rd_data
);
    import hpt_pkg::*;

    localparam logic [COORD_W-1:0] ONE_FX = COORD_W'(1) << FRAC_BITS;

    logic [COORD_W-1:0]   mem [MAT_DEPTH];
    logic [MAT_DEPTH-1:0] vld_reg;
    logic [COORD_W-1:0]   mem_q_reg;
    logic                 vld_q_reg;
    logic [COORD_W-1:0]   dflt_q_reg;
    logic [COORD_W-1:0]   dflt;

    always_comb
    begin
        if (cmd.rd_addr[5:4] == SEL_FWD && cmd.rd_addr[3:2] == cmd.rd_addr[1:0])
        begin
            dflt = ONE_FX;
        end
        else
        begin
            dflt = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.ident_load)
        begin
            vld_reg[MAT_ENTRIES-1:0] <= '0;
        end
        else if (cmd.wr_en)
        begin
            vld_reg[cmd.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg  <= mem[cmd.rd_addr];
            vld_q_reg  <= vld_reg[cmd.rd_addr];
            dflt_q_reg <= dflt;
        end
    end

    assign rd_data = vld_q_reg ? mem_q_reg : dflt_q_reg;

endmodule

// ===== rtl/hpt_row_mac.sv =====
// Row multiply-accumulate: one product per cycle, four products per row sum.
module hpt_row_mac #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hpt_pkg::mac_tag_t           tag,
    input  logic [hpt_pkg::COORD_W-1:0] coef,
    input  hpt_pkg::vec4_t              point,
    output hpt_pkg::acc4_t              sums,
    output logic                        done
);
    import hpt_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic signed [2*COORD_W-1:0] prod_reg;
    mac_tag_t                    tag1_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    acc4_t                       sums_reg;
    logic                        done_reg;
    logic                        done_next;
    logic signed [ACC_W-1:0]     base;
    logic signed [ACC_W-1:0]     sum;

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(coef) * $signed(point[tag.idx[1:0]]);
    end

    always_comb
    begin
        base      = (tag1_reg.idx[1:0] == 2'd0) ? HALF : acc_reg;
        sum       = base + ACC_W'(prod_reg);
        done_next = tag1_reg.valid && (&tag1_reg.idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            tag1_reg <= tag;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag1_reg.valid)
        begin
            if (&tag1_reg.idx[1:0])
            begin
                sums_reg[tag1_reg.idx[3:2]] <= sum >>> FRAC_BITS;
            end
            else
            begin
                acc_reg <= sum;
            end
        end
    end

    assign sums = sums_reg;
    assign done = done_reg;

endmodule

// ===== rtl/hpt_div_lane.sv =====
// Division lane: perspective divide of one coordinate, one quotient bit per cycle.
module hpt_div_lane #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [hpt_pkg::ACC_W-1:0] r,
    input  logic signed [hpt_pkg::ACC_W-1:0] w,
    output hpt_pkg::lane_res_t               res
);
    import hpt_pkg::*;

    localparam int QI = COORD_W - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ONE_W = ACC_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] POS_MAX = ACC_W'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic [ACC_W-1:0] NEG_MAX = ACC_W'(1) << (COORD_W - 1);

    dv_state_t          st_reg, st_next;
    logic [ACC_W-1:0]   a_reg, a_next;
    logic [ACC_W-1:0]   d_reg, d_next;
    logic               neg_reg, neg_next;
    logic               div_reg, div_next;
    logic [ACC_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   low_reg, low_next;
    logic [QUO_W-1:0]   q_reg, q_next;
    logic [5:0]         step_reg, step_next;
    logic [ACC_W-1:0]   mag_reg, mag_next;
    lane_res_t          res_reg, res_next;
    logic [ACC_W:0]     p;
    logic               ge;
    logic               ovf;

    always_comb
    begin
        st_next   = st_reg;
        a_next    = a_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        step_next = step_reg;
        mag_next  = mag_reg;
        res_next  = res_reg;
        p   = {rem_reg, low_reg[QUO_W-1]};
        ge  = p >= {1'b0, d_reg};
        ovf = {{QI{1'b0}}, a_reg} >= {d_reg, {QI{1'b0}}};
        unique case (st_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    a_next        = (r < 0) ? ACC_W'(-r) : ACC_W'(r);
                    d_next        = (w < 0) ? ACC_W'(-w) : ACC_W'(w);
                    neg_next      = r < 0;
                    div_next      = (w < 0) || (w > 0 && w < ONE_W);
                    res_next.done = 1'b0;
                    st_next       = DV_CHK;
                end
            end
            DV_CHK:
            begin
                if (!div_reg)
                begin
                    mag_next = a_reg;
                    st_next  = DV_FIN;
                end
                else if (ovf)
                begin
                    mag_next = '1;
                    st_next  = DV_FIN;
                end
                else
                begin
                    rem_next  = a_reg >> QI;
                    low_next  = QUO_W'(a_reg[QI-1:0]) << (FRAC_BITS + 1);
                    q_next    = '0;
                    step_next = '0;
                    st_next   = DV_RUN;
                end
            end
            DV_RUN:
            begin
                rem_next  = ge ? ACC_W'(p - {1'b0, d_reg}) : ACC_W'(p);
                q_next    = {q_reg[QUO_W-2:0], ge};
                low_next  = {low_reg[QUO_W-2:0], 1'b0};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(QUO_W - 1))
                begin
                    st_next = DV_RND;
                end
            end
            DV_RND:
            begin
                mag_next = ACC_W'(q_reg[QUO_W-1:1]) + ACC_W'(q_reg[0]);
                st_next  = DV_FIN;
            end
            DV_FIN:
            begin
                if (neg_reg)
                begin
                    res_next.sat   = mag_reg > NEG_MAX;
                    res_next.value = (mag_reg > NEG_MAX) ? NEG_MAX[COORD_W-1:0]
                                                         : COORD_W'(-mag_reg);
                end
                else
                begin
                    res_next.sat   = mag_reg > POS_MAX;
                    res_next.value = (mag_reg > POS_MAX) ? POS_MAX[COORD_W-1:0]
                                                         : mag_reg[COORD_W-1:0];
                end
                res_next.done = 1'b1;
                st_next       = DV_IDLE;
            end
            default:
            begin
                st_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= DV_IDLE;
            res_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        mag_reg  <= mag_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/homogeneous_point_transform.sv =====
// Top level of the homogeneous point transform: control, store, MAC and divide lanes.
//
// One item is worked on at a time. A matrix entry write or an identity load is done
// straight from the idle state. With the identity flag set a transform passes the point
// through. Otherwise the sixteen entries of the chosen matrix are read from the store
// one per cycle into one 32x32 multiplier, which forms the row sums; three divide lanes
// then work in parallel, each a restoring divider giving one quotient bit per cycle over
// 33 steps. A lane skips the division when no perspective divide is needed. The result
// sits in an output register, so the next item is taken while it waits. The store keeps
// a valid bit per entry, so it needs no clearing pass after reset.
module homogeneous_point_transform #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  hpt_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output hpt_pkg::result_t  result
);
    import hpt_pkg::*;

    hpt_state_t         state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [1:0]         sel_reg, sel_next;
    vec4_t              point_reg, point_next;
    logic               pass_reg, pass_next;
    logic               identity_reg, identity_next;
    result_t            result_reg, result_next;
    logic               result_valid_reg, result_valid_next;
    mac_tag_t           tag_reg, tag_next;
    store_cmd_t         store_cmd;
    logic [COORD_W-1:0] rd_data;
    acc4_t              sums;
    logic               mac_done;
    lane_res_t          lane_res [3];
    logic               lane_start;
    logic               accept;
    logic               emit_fire;

    hpt_mat_store #(
        .FRAC_BITS(FRAC_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (store_cmd),
        .rd_data (rd_data)
    );

    hpt_row_mac #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .tag   (tag_reg),
        .coef  (rd_data),
        .point (point_reg),
        .sums  (sums),
        .done  (mac_done)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        hpt_div_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (lane_start),
            .r     ($signed(sums[k])),
            .w     ($signed(sums[3])),
            .res   (lane_res[k])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        sel_next          = sel_reg;
        point_next        = point_reg;
        pass_next         = pass_reg;
        identity_next     = identity_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        store_cmd         = '0;
        lane_start        = 1'b0;
        accept            = item_valid && (state_reg == ST_IDLE);
        emit_fire         = (state_reg == ST_EMIT) && (!result_valid_reg || !result_stall);
        tag_next.valid    = state_reg == ST_READ;
        tag_next.idx      = cnt_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.opcode)
                        OP_WRITE:
                        begin
                            if (item.matrix_sel != SEL_NONE)
                            begin
                                store_cmd.wr_en   = 1'b1;
                                store_cmd.wr_addr = {item.matrix_sel, item.entry_index};
                                store_cmd.wr_data = item.entry_value;
                                if (item.matrix_sel == SEL_FWD)
                                begin
                                    identity_next = 1'b0;
                                end
                            end
                        end
                        OP_IDENT:
                        begin
                            store_cmd.ident_load = 1'b1;
                            identity_next        = 1'b1;
                        end
                        OP_XFORM:
                        begin
                            point_next = {item.w_in, item.z_in, item.y_in, item.x_in};
                            sel_next   = item.matrix_sel;
                            if (identity_reg)
                            begin
                                pass_next  = 1'b1;
                                state_next = ST_EMIT;
                            end
                            else if (item.matrix_sel != SEL_NONE)
                            begin
                                pass_next  = 1'b0;
                                cnt_next   = '0;
                                state_next = ST_READ;
                            end
                        end
                        OP_NONE:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                store_cmd.rd_en   = 1'b1;
                store_cmd.rd_addr = {sel_reg, cnt_reg};
                cnt_next          = cnt_reg + 4'd1;
                if (cnt_reg == 4'(MAT_ENTRIES - 1))
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                lane_start = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (lane_res[0].done && lane_res[1].done && lane_res[2].done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    if (pass_reg)
                    begin
                        result_next.x_out     = point_reg[0];
                        result_next.y_out     = point_reg[1];
                        result_next.z_out     = point_reg[2];
                        result_next.saturated = 1'b0;
                    end
                    else
                    begin
                        result_next.x_out     = lane_res[0].value;
                        result_next.y_out     = lane_res[1].value;
                        result_next.z_out     = lane_res[2].value;
                        result_next.saturated = lane_res[0].sat || lane_res[1].sat
                                                || lane_res[2].sat;
                    end
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            identity_reg     <= 1'b1;
            result_valid_reg <= 1'b0;
            tag_reg          <= '0;
            pass_reg         <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            identity_reg     <= identity_next;
            result_valid_reg <= result_valid_next;
            tag_reg          <= tag_next;
            pass_reg         <= pass_next;
            cnt_reg          <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        point_reg  <= point_next;
        result_reg <= result_next;
    end

    assign item_stall   = state_reg != ST_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == ST_MAC)
        else $error("row sums finished outside the accumulate phase");

    a_lanes_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $past(lane_start) |-> !lane_res[0].done && !lane_res[1].done && !lane_res[2].done)
        else $error("divide lane still flags done after a new start");

    a_pass_clean: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire && pass_reg |=> result_valid && !result.saturated)
        else $error("pass-through beat flagged as saturated");

    a_ident_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        store_cmd.ident_load |=> identity_reg)
        else $error("identity load did not set the identity flag");

endmodule
